FILE: design/write_ahead_log_controller_assert.svh
// Assertion macros shared by the write-ahead log controller.
// Depends on nothing; included inside the module body of the files that assert.
`ifndef WRITE_AHEAD_LOG_CONTROLLER_ASSERT_SVH
`define WRITE_AHEAD_LOG_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define WAL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("write-ahead log controller: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define WAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("write-ahead log controller: next-cycle check failed");

`endif

FILE: design/wal_pkg.sv
// Shared types and constants for the write-ahead log controller.
// Depends on nothing; imported by the front end, back end and top level.
package wal_pkg;

    // Default sizing
    localparam int LOG_ENTRIES_DEF   = 30;
    localparam int MAX_OP_BLOCKS_DEF = 10;
    localparam int QUEUE_DEPTH       = 2;

    // Width of the begin admission sum: entries + (open + 1) * reservation
    localparam int NEED_W = 12;

    // Reset value of the log area size
    localparam logic [15:0] LOG_SIZE_RST = 16'd31;

    // Configuration register indexes
    localparam logic CFG_LOG_START = 1'b0;
    localparam logic CFG_LOG_SIZE  = 1'b1;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_WRITE = 2'd1,
        OP_END   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        KIND_REPLY   = 3'd0,
        KIND_COPY    = 3'd1,
        KIND_HEADER  = 3'd2,
        KIND_INSTALL = 3'd3,
        KIND_CLEAR   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_WAIT     = 3'd1,
        STS_FULL     = 3'd2,
        STS_OUTSIDE  = 3'd3,
        STS_NO_BEGIN = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REPLY,
        S_COPY,
        S_HEADER,
        S_INSTALL,
        S_CLEAR
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] block_no;
    } t_req;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [4:0]  entry_index;
        logic [31:0] src_block;
        logic [31:0] dst_block;
        logic [4:0]  head_count;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [31:0] log_start;
        logic [15:0] log_size;
    } t_cfg;

endpackage

FILE: design/wal_ram.sv
// Generic simple dual-port RAM with registered read data.
// Depends on nothing.
module wal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: hold the last word until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/wal_fifo.sv
// Small register queue of generic width, first in first out.
// Depends on wal_pkg for its default depth.
module wal_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = wal_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wptr = do_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr = do_pop ? ptr_inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

FILE: design/wal_front.sv
// Front end: accepts requests, drops unknown request kinds, queues the rest.
// Depends on wal_pkg and wal_fifo.
module wal_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wal_pkg::t_req i_req,
    output logic          o_full,
    output wal_pkg::t_req o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);

    import wal_pkg::*;

    logic                  known_op;
    logic                  q_empty;
    logic [$bits(t_req)-1:0] q_rdata;

    // Classify the request kind
    always_comb begin
        case (i_req.op)
            OP_BEGIN: known_op = 1'b1;
            OP_WRITE: known_op = 1'b1;
            OP_END:   known_op = 1'b1;
            default:  known_op = 1'b0;
        endcase
    end

    // Queue decoded requests towards the back end
    wal_fifo #(
        .WIDTH ($bits(t_req)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && known_op),
        .i_wdata (i_req),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign o_cmd       = t_req'(q_rdata);
    assign o_cmd_valid = !q_empty;

endmodule

FILE: design/wal_back.sv
// Back end: carries out begin, write and end requests and sequences the commit.
// Depends on wal_pkg and wal_ram (the block number table).
module wal_back #(
    parameter int LOG_ENTRIES   = wal_pkg::LOG_ENTRIES_DEF,
    parameter int MAX_OP_BLOCKS = wal_pkg::MAX_OP_BLOCKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wal_pkg::t_cfg i_cfg,
    input  wal_pkg::t_req i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    output wal_pkg::t_res o_res,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output logic          o_idle
);

    import wal_pkg::*;

    localparam int IW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
    localparam int CW = $clog2(LOG_ENTRIES + 1);

    t_state        r_state, n_state;
    logic [4:0]    r_open, n_open;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [31:0]   r_blk, n_blk;
    t_status       r_status, n_status;
    logic          r_commit, n_commit;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [NEED_W-1:0] need;
    logic              begin_room;
    logic              tbl_full;
    logic              wr_go;
    logic [CW-1:0]     idx_next;
    logic              more;
    logic              hit;
    logic [31:0]       log_blk;

    // Block number table
    wal_ram #(
        .WIDTH (32),
        .DEPTH (LOG_ENTRIES),
        .AW    (IW)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Request checks and loop bookkeeping
    assign need       = NEED_W'(r_count)
                      + NEED_W'(6'(r_open) + 6'd1) * NEED_W'(MAX_OP_BLOCKS);
    assign begin_room = (need <= NEED_W'(LOG_ENTRIES));
    assign tbl_full   = (r_count >= CW'(LOG_ENTRIES))
                     || ((16'(r_count) + 16'd1) >= i_cfg.log_size);
    assign wr_go      = !tbl_full && (r_open != 5'd0);
    assign idx_next   = CW'(r_idx) + CW'(1);
    assign more       = (idx_next < r_count);
    assign hit        = (ram_rdata == r_blk);
    assign log_blk    = i_cfg.log_start + 32'(r_idx) + 32'd1;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_BEGIN: n_state = S_REPLY;
                        OP_WRITE: n_state = (wr_go && r_count != '0) ? S_SCAN : S_REPLY;
                        OP_END:   n_state = S_REPLY;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit || !more) begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (i_res_ready) begin
                    n_state = r_commit ? S_COPY : S_IDLE;
                end
            end
            S_COPY: begin
                if (i_res_ready && !more) begin
                    n_state = S_HEADER;
                end
            end
            S_HEADER: begin
                if (i_res_ready) begin
                    n_state = S_INSTALL;
                end
            end
            S_INSTALL: begin
                if (i_res_ready && !more) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Next transaction state, table index and reply status
    always_comb begin
        n_open   = r_open;
        n_count  = r_count;
        n_idx    = r_idx;
        n_blk    = r_blk;
        n_status = r_status;
        n_commit = r_commit;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_idx    = '0;
                    n_commit = 1'b0;
                    case (i_cmd.op)
                        OP_BEGIN: begin
                            if (begin_room) begin
                                n_open   = r_open + 5'd1;
                                n_status = STS_OK;
                            end else begin
                                n_status = STS_WAIT;
                            end
                        end
                        OP_WRITE: begin
                            n_blk = i_cmd.block_no;
                            if (tbl_full) begin
                                n_status = STS_FULL;
                            end else if (r_open == 5'd0) begin
                                n_status = STS_OUTSIDE;
                            end else begin
                                n_status = STS_OK;
                                if (r_count == '0) begin
                                    n_count = CW'(1);
                                end
                            end
                        end
                        OP_END: begin
                            if (r_open == 5'd0) begin
                                n_status = STS_NO_BEGIN;
                            end else begin
                                n_open   = r_open - 5'd1;
                                n_status = STS_OK;
                                n_commit = (r_open == 5'd1) && (r_count != '0);
                            end
                        end
                        default: n_status = r_status;
                    endcase
                end
            end
            S_SCAN: begin
                if (!hit) begin
                    if (more) begin
                        n_idx = IW'(idx_next);
                    end else begin
                        n_idx   = r_count[IW-1:0];
                        n_count = r_count + CW'(1);
                    end
                end
            end
            S_REPLY: begin
                if (i_res_ready && r_commit) begin
                    n_idx = '0;
                end
            end
            S_COPY: begin
                if (i_res_ready) begin
                    n_idx = more ? IW'(idx_next) : '0;
                end
            end
            S_INSTALL: begin
                if (i_res_ready && more) begin
                    n_idx = IW'(idx_next);
                end
            end
            S_CLEAR: begin
                if (i_res_ready) begin
                    n_count = '0;
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    // Outputs: request pop, table access and result word
    always_comb begin
        o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
        o_idle      = (r_state == S_IDLE);
        o_res_valid = 1'b0;
        o_res       = '0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = r_blk;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_WRITE && wr_go) begin
                    if (r_count == '0) begin
                        ram_we    = 1'b1;
                        ram_wdata = i_cmd.block_no;
                    end else begin
                        ram_re = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (!hit) begin
                    if (more) begin
                        ram_re    = 1'b1;
                        ram_raddr = IW'(idx_next);
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[IW-1:0];
                    end
                end
            end
            S_REPLY: begin
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_REPLY;
                o_res.status      = r_status;
                o_res.entry_index = 5'(r_idx);
                o_res.last        = !r_commit;
                ram_re            = i_res_ready && r_commit;
            end
            S_COPY: begin
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_COPY;
                o_res.entry_index = 5'(r_idx);
                o_res.src_block   = ram_rdata;
                o_res.dst_block   = log_blk;
                ram_re            = i_res_ready && more;
                ram_raddr         = IW'(idx_next);
            end
            S_HEADER: begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_HEADER;
                o_res.head_count = 5'(r_count);
                ram_re           = i_res_ready;
            end
            S_INSTALL: begin
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_INSTALL;
                o_res.entry_index = 5'(r_idx);
                o_res.src_block   = log_blk;
                o_res.dst_block   = ram_rdata;
                ram_re            = i_res_ready && more;
                ram_raddr         = IW'(idx_next);
            end
            S_CLEAR: begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_CLEAR;
                o_res.last  = 1'b1;
            end
            default: o_res_valid = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= '0;
            r_count  <= '0;
            r_commit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_open   <= n_open;
            r_count  <= n_count;
            r_commit <= n_commit;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_blk    <= n_blk;
        r_status <= n_status;
    end

endmodule

FILE: design/write_ahead_log_controller.sv
// Write-ahead log controller: requests are taken in through a two-entry queue
// and handled one at a time by the back end; results leave through a two-entry
// result queue, so a new request is taken while results still wait to be popped.
// A begin or an end gives a single reply; a write compares its block number
// with the table entries in turn, since the block number table is read one
// entry a cycle through its registered read port.
// A commit streams its 2 * entries + 3 results at one a cycle while the result
// queue has room.
// Depends on wal_pkg, wal_front, wal_back, wal_fifo and wal_ram.
module write_ahead_log_controller #(
    parameter int LOG_ENTRIES   = wal_pkg::LOG_ENTRIES_DEF,
    parameter int MAX_OP_BLOCKS = wal_pkg::MAX_OP_BLOCKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request queue side
    input  logic          push,
    input  wal_pkg::t_req i_req,
    output logic          full,
    // result queue side
    output logic          empty,
    input  logic          pop,
    output wal_pkg::t_res o_res,
    // configuration writes
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    import wal_pkg::*;

    logic        [31:0]     r_log_start;
    logic        [15:0]     r_log_size;
    t_cfg                   cfg;
    t_req                   cmd;
    logic                   cmd_valid;
    logic                   cmd_pop;
    t_res                   res;
    logic                   res_valid;
    logic                   res_ready;
    logic                   res_full;
    logic                   back_idle;
    logic [$bits(t_res)-1:0] out_rdata;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_start <= '0;
            r_log_size  <= LOG_SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOG_START: r_log_start <= i_cfg_data;
                CFG_LOG_SIZE:  r_log_size  <= i_cfg_data[15:0];
                default:       r_log_start <= r_log_start;
            endcase
        end
    end

    assign cfg.log_start = r_log_start;
    assign cfg.log_size  = r_log_size;

    // Accept and classify requests
    wal_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req       (i_req),
        .o_full      (full),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Execute requests and sequence commits
    wal_back #(
        .LOG_ENTRIES   (LOG_ENTRIES),
        .MAX_OP_BLOCKS (MAX_OP_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_idle      (back_idle)
    );

    // Hold results until popped
    wal_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_wdata (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty)
    );

    assign res_ready = !res_full;
    assign o_res     = t_res'(out_rdata);

    `include "write_ahead_log_controller_assert.svh"

    // A request is taken from the queue only by an idle back end
    `WAL_ASSERT_IMPLY(a_pop_when_idle, i_clk, i_rst_n, cmd_pop, back_idle)
    // The final result of a request returns the back end to idle
    `WAL_ASSERT_NEXT(a_last_then_idle, i_clk, i_rst_n, res_valid && res_ready && res.last, back_idle)
    // The header clear closes every commit
    `WAL_ASSERT_IMPLY(a_clear_is_last, i_clk, i_rst_n, res_valid && res.kind == KIND_CLEAR, res.last)
    // Disk commands carry no status
    `WAL_ASSERT_IMPLY(a_cmd_status_ok, i_clk, i_rst_n, res_valid && res.kind != KIND_REPLY, res.status == STS_OK)

endmodule
